// ===== rtl/core/sbi_pkg.sv =====
`timescale 1ns / 1ps
package sbi_pkg;

  // Largest FFT length taken; a longer sample count is clamped to this
  localparam int MAX_POINTS = 4096;

  // 1/(2*pi) and 1/(4*pi^2) as 32-bit fractions
  localparam logic [29:0] K_ONCE  = 30'd683565276;
  localparam logic [29:0] K_TWICE = 30'd108792793;

  // Widths of the scaled numerator, the divisor and the quotient
  localparam int HW   = 72;
  localparam int DENW = 56;
  localparam int QB   = 16;

  typedef enum logic [2:0] {
    REG_RATE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_FLOW  = 3'd2,
    REG_FHIGH = 3'd3,
    REG_SCALE = 3'd4,
    REG_TWICE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] rate;
    logic [12:0] count;
    logic [15:0] flow;
    logic [15:0] fhigh;
    logic [15:0] scale;
    logic        twice;
  } cfg_t;

  // Per-bin sideband that travels down the pipeline
  typedef struct packed {
    logic [11:0] bin;
    logic [11:0] bin_m;
    logic        mirror;
    logic        inband;
    logic        neg_a;
    logic        neg_b;
  } meta_t;

endpackage

// ===== rtl/core/sbi_gain.sv =====
`timescale 1ns / 1ps
module sbi_gain (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [11:0]               bin,
  input  logic signed [15:0]        re_in,
  input  logic signed [15:0]        im_in,
  input  sbi_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output sbi_pkg::meta_t            out_meta,
  output logic [sbi_pkg::HW-1:0]    out_h [2],
  output logic [sbi_pkg::DENW-1:0]  out_den
);
  import sbi_pkg::*;

  logic [12:0]        n;
  logic [15:0]        rate;
  logic [11:0]        half;
  logic signed [15:0] src [2];
  logic [15:0]        mag [2];
  logic               neg [2];
  logic [29:0]        kc;

  // Clamp configuration and pick the source of each lane
  always_comb begin
    n = (cfg.count > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : cfg.count;
    rate = (cfg.rate == 16'd0) ? 16'd1 : cfg.rate;
    half = n[12:1];
    kc = cfg.twice ? K_TWICE : K_ONCE;
    src[0] = cfg.twice ? re_in : im_in;
    src[1] = cfg.twice ? im_in : re_in;
    for (int l = 0; l < 2; l++) begin
      mag[l] = src[l][15] ? (16'(~src[l]) + 16'd1) : 16'(src[l]);
    end
    neg[0] = cfg.twice ? !src[0][15] : src[0][15];
    neg[1] = !src[1][15];
  end

  // Stage 1: magnitude times constant, gain factors, divisor, band products
  logic        v1;
  meta_t       m1;
  logic [45:0] mk1 [2];
  logic [31:0] gs1;
  logic [25:0] gn1;
  logic [27:0] den1;
  logic [28:0] ip1, fl1, fh1;
  logic        tw1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid && (bin <= half);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) mk1[l] <= 46'(mag[l]) * 46'(kc);
      gs1 <= cfg.twice ? 32'(cfg.scale) * 32'(cfg.scale) : 32'(cfg.scale);
      gn1 <= cfg.twice ? 26'(n) * 26'(n) : 26'(n);
      den1 <= 28'(rate) * 28'(bin);
      ip1 <= 29'(rate) * (29'(bin) + 29'd1);
      fl1 <= 29'(cfg.flow) * 29'(n);
      fh1 <= 29'(cfg.fhigh) * 29'(n);
      tw1 <= cfg.twice;
      m1.bin <= bin;
      m1.bin_m <= 12'(n - 13'(bin));
      m1.mirror <= (bin != 12'd0) && (bin < half);
      m1.inband <= 1'b0;
      m1.neg_a <= neg[0];
      m1.neg_b <= neg[1];
    end
  end

  // Stage 2: partial products with the scale factor, divisor squared when twice is set, band test
  logic        v2;
  meta_t       m2;
  logic [63:0] plo2 [2];
  logic [45:0] phi2 [2];
  logic [25:0] gn2;
  logic [DENW-1:0] den2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        plo2[l] <= 64'(mk1[l][31:0]) * 64'(gs1);
        phi2[l] <= 46'(mk1[l][45:32]) * 46'(gs1);
      end
      gn2 <= gn1;
      den2 <= tw1 ? DENW'(den1) * DENW'(den1) : DENW'(den1);
      m2.bin <= m1.bin;
      m2.bin_m <= m1.bin_m;
      m2.mirror <= m1.mirror;
      m2.neg_a <= m1.neg_a;
      m2.neg_b <= m1.neg_b;
      m2.inband <= (m1.bin != 12'd0) && (ip1 > fl1) && (ip1 <= fh1);
    end
  end

  // Stage 3: merge the partial products
  logic        v3;
  meta_t       m3;
  logic [77:0] ma3 [2];
  logic [25:0] gn3;
  logic [DENW-1:0] den3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) ma3[l] <= 78'(plo2[l]) + (78'(phi2[l]) << 32);
      gn3 <= gn2;
      den3 <= den2;
      m3 <= m2;
    end
  end

  // Stage 4: three slices times the length factor
  logic        v4;
  meta_t       m4;
  logic [51:0] pp4 [2][3];
  logic [DENW-1:0] den4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        pp4[l][0] <= 52'(ma3[l][25:0]) * 52'(gn3);
        pp4[l][1] <= 52'(ma3[l][51:26]) * 52'(gn3);
        pp4[l][2] <= 52'(ma3[l][77:52]) * 52'(gn3);
      end
      den4 <= den3;
      m4 <= m3;
    end
  end

  // Stage 5: full numerator
  logic         v5;
  meta_t        m5;
  logic [103:0] num5 [2];
  logic [DENW-1:0] den5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        num5[l] <= 104'(pp4[l][0]) + (104'(pp4[l][1]) << 26) + (104'(pp4[l][2]) << 52);
      end
      den5 <= den4;
      m5 <= m4;
    end
  end

  // Stage 6: add half the divisor for rounding, drop the fraction bits
  logic            v6;
  meta_t           m6;
  logic [HW-1:0]   h6 [2];
  logic [DENW-1:0] den6;
  logic [103:0]    rsum [2];

  always_comb begin
    for (int l = 0; l < 2; l++) rsum[l] = num5[l] + (104'(den5) << 31);
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) h6[l] <= rsum[l][HW+31:32];
      den6 <= den5;
      m6 <= m5;
    end
  end

  assign out_valid = v6;
  assign out_meta  = m6;
  assign out_h     = h6;
  assign out_den   = den6;

endmodule

// ===== rtl/core/sbi_div.sv =====
`timescale 1ns / 1ps
module sbi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  sbi_pkg::meta_t            in_meta,
  input  logic [sbi_pkg::HW-1:0]    in_h [2],
  input  logic [sbi_pkg::DENW-1:0]  in_den,
  output logic                      out_valid,
  output sbi_pkg::meta_t            out_meta,
  output logic [sbi_pkg::QB-1:0]    out_q [2]
);
  import sbi_pkg::*;

  logic            v [QB];
  meta_t           m [QB];
  logic [HW-1:0]   r [QB][2];
  logic [QB-1:0]   q [QB][2];
  logic [DENW-1:0] d [QB];

  // One restoring step per stage, top quotient bit first; top bit flags overflow
  for (genvar st = 0; st < QB; st++) begin : g_st
    localparam int SH = QB - 1 - st;
    logic            pv;
    meta_t           pm;
    logic [HW-1:0]   pr [2];
    logic [QB-1:0]   pq [2];
    logic [DENW-1:0] pd;
    logic [HW-1:0]   dsh;

    if (st == 0) begin : g_first
      assign pv = in_valid;
      assign pm = in_meta;
      assign pr = in_h;
      assign pq[0] = '0;
      assign pq[1] = '0;
      assign pd = in_den;
    end else begin : g_next
      assign pv = v[st-1];
      assign pm = m[st-1];
      assign pr = r[st-1];
      assign pq = q[st-1];
      assign pd = d[st-1];
    end

    assign dsh = HW'(pd) << SH;

    always_ff @(posedge clk) begin
      if (rst) v[st] <= 1'b0;
      else if (adv) v[st] <= pv;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m[st] <= pm;
        d[st] <= pd;
        for (int l = 0; l < 2; l++) begin
          if (pr[l] >= dsh) begin
            r[st][l] <= pr[l] - dsh;
            q[st][l] <= pq[l] | (QB'(1) << SH);
          end else begin
            r[st][l] <= pr[l];
            q[st][l] <= pq[l];
          end
        end
      end
    end
  end

  assign out_valid = v[QB-1];
  assign out_meta  = m[QB-1];
  assign out_q     = q[QB-1];

endmodule

// ===== rtl/core/sbi_out.sv =====
`timescale 1ns / 1ps
module sbi_out (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  sbi_pkg::meta_t         in_meta,
  input  logic [sbi_pkg::QB-1:0] in_q [2],
  output logic                   adv,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic [11:0]            bin_out,
  output logic signed [15:0]     re_out,
  output logic signed [15:0]     im_out,
  output logic                   run_last
);
  import sbi_pkg::*;

  // Saturate a quotient and apply its sign; top bit set means at least 32768
  function automatic logic [15:0] sat_q(input logic [15:0] qv, input logic ng);
    logic [15:0] res;
    if (ng) res = qv[15] ? 16'h8000 : (~qv + 16'd1);
    else    res = qv[15] ? 16'h7fff : qv;
    return res;
  endfunction

  logic        o_valid, o_second, o_mirror;
  logic [11:0] o_bin, o_bin_m;
  logic [15:0] o_re, o_im;
  logic [15:0] re_n, im_n, im_m;
  logic        take_last;

  always_comb begin
    re_n = in_meta.inband ? sat_q(in_q[0], in_meta.neg_a) : 16'd0;
    im_n = in_meta.inband ? sat_q(in_q[1], in_meta.neg_b) : 16'd0;
    im_m = (o_im == 16'h8000) ? 16'h7fff : (~o_im + 16'd1);
  end

  assign take_last = o_valid && m_ready && (o_second || !o_mirror);
  assign adv = !o_valid || take_last;

  // Hold the bin for one or two beats; load the next on the last beat
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      o_second <= 1'b0;
    end else if (adv) begin
      o_valid <= in_valid;
      o_second <= 1'b0;
    end else if (o_valid && m_ready) begin
      o_second <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_bin <= in_meta.bin;
      o_bin_m <= in_meta.bin_m;
      o_mirror <= in_meta.mirror;
      o_re <= re_n;
      o_im <= im_n;
    end
  end

  assign m_valid  = o_valid;
  assign bin_out  = o_second ? o_bin_m : o_bin;
  assign re_out   = $signed(o_re);
  assign im_out   = $signed(o_second ? im_m : o_im);
  assign run_last = o_second || !o_mirror;

  a_second_is_mirror: assert property (@(posedge clk) disable iff (rst)
    o_second |-> (o_valid && o_mirror))
    else $error("mirror beat without a mirrored bin");

  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !o_second && o_mirror && m_ready) |=> o_second)
    else $error("mirror beat did not follow the direct beat");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !m_ready) |=> (o_valid && !adv == !adv))
    else $error("result dropped while stalled");

endmodule

// ===== rtl/core/spectrum_band_integrate.sv =====
`timescale 1ns / 1ps
// Path: a bin accepted at one edge passes 6 gain stages, 16 divider stages and
// 1 output register before its first result beat shows (the first stage loads
// at the accepting edge). Throughput: one bin a cycle for unmirrored bins while
// the output is not stalled; a bin with a mirror holds the input until the
// single result channel has carried both of its beats.
// Reset (synchronous, rst high): pipeline emptied, registers to their defaults.
module spectrum_band_integrate (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // bin_index[11:0], re_in[27:12], im_in[43:28]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // bin_out[11:0], re_out[27:12], im_out[43:28]
  output logic        m_axis_tlast
);
  import sbi_pkg::*;

  cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate  <= 16'd3200;
      cfg.count <= 13'd4096;
      cfg.flow  <= 16'd0;
      cfg.fhigh <= 16'd65535;
      cfg.scale <= 16'd1;
      cfg.twice <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RATE:  cfg.rate  <= cfg_wdata;
        REG_COUNT: cfg.count <= cfg_wdata[12:0];
        REG_FLOW:  cfg.flow  <= cfg_wdata;
        REG_FHIGH: cfg.fhigh <= cfg_wdata;
        REG_SCALE: cfg.scale <= cfg_wdata;
        REG_TWICE: cfg.twice <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic            adv;
  logic            g_valid, d_valid;
  meta_t           g_meta, d_meta;
  logic [HW-1:0]   g_h [2];
  logic [DENW-1:0] g_den;
  logic [QB-1:0]   d_q [2];
  logic [11:0]     bin_out;
  logic signed [15:0] re_out, im_out;

  assign s_axis_tready = adv;

  sbi_gain u_gain (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(s_axis_tvalid),
    .bin(s_axis_tdata[11:0]),
    .re_in($signed(s_axis_tdata[27:12])),
    .im_in($signed(s_axis_tdata[43:28])),
    .cfg(cfg),
    .out_valid(g_valid), .out_meta(g_meta), .out_h(g_h), .out_den(g_den)
  );

  sbi_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(g_valid), .in_meta(g_meta), .in_h(g_h), .in_den(g_den),
    .out_valid(d_valid), .out_meta(d_meta), .out_q(d_q)
  );

  sbi_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(d_valid), .in_meta(d_meta), .in_q(d_q),
    .adv(adv),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .bin_out(bin_out), .re_out(re_out), .im_out(im_out),
    .run_last(m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, im_out, re_out, bin_out};

endmodule
